### rtl/adsr_pkg.sv
// Package for the linear ADSR envelope level shaper.
// Holds the phase codes, sequencer states and configuration register indexes.
// No dependencies.
package adsr_pkg;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_BYPASS  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } cfg_reg_t;

endpackage

### rtl/adsr_envelope_level.sv
// Linear ADSR envelope level shaper for one voice, top level.
// Bit-serial shift-add multiplier and restoring divider under one sequencer.
// Depends on adsr_pkg.
// Attack and decay items pass ST_MUL_T, ST_SETUP, ST_MUL, ST_DIV and ST_FINISH; sustain
// items skip ST_MUL and ST_DIV, release ramps skip ST_MUL_T, the end of release goes from
// ST_SETUP to ST_FINISH, and bypass goes straight to ST_FINISH.
// One item at a time; the serial multiplier (one bit per cycle) and divider set the rate,
// and a result waiting for out_ready holds the next item back. A new transfer is taken on
// the cycle after the result is loaded into the output register.
// Reset (rst_n low, asynchronous) restores register defaults and clears both stored levels.
module adsr_envelope_level #(
    parameter int TIME_BITS  = 24,
    parameter int LEVEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [((TIME_BITS > LEVEL_BITS + 1) ? TIME_BITS : LEVEL_BITS + 1)-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [LEVEL_BITS-1:0]              value,
    input  logic                               note_active,
    input  logic                               pressed,
    input  logic [TIME_BITS-1:0]               since_press,
    input  logic [TIME_BITS-1:0]               since_release,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [LEVEL_BITS-1:0]              level,
    output adsr_pkg::phase_t                   phase
);
    import adsr_pkg::*;

    localparam int MW = (TIME_BITS > LEVEL_BITS + 1) ? TIME_BITS : LEVEL_BITS + 1;
    localparam int PW = LEVEL_BITS + 1 + MW;
    localparam int CW = $clog2(MW + 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(MW - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(LEVEL_BITS - 1);
    localparam logic [LEVEL_BITS:0] SUS_ONE = {1'b1, {LEVEL_BITS{1'b0}}};
    localparam logic [LEVEL_BITS:0] SUS_RST = {2'b01, {(LEVEL_BITS-1){1'b0}}};
    localparam logic [TIME_BITS-1:0] ATTACK_RST  = TIME_BITS'(480);
    localparam logic [TIME_BITS-1:0] DECAY_RST   = TIME_BITS'(4800);
    localparam logic [TIME_BITS-1:0] RELEASE_RST = TIME_BITS'(4800);

    state_t                  state_reg, state_next;
    logic [TIME_BITS-1:0]    attack_reg, attack_next;
    logic [TIME_BITS-1:0]    decay_reg, decay_next;
    logic [LEVEL_BITS:0]     sustain_reg, sustain_next;
    logic [TIME_BITS-1:0]    release_reg, release_next;
    logic [LEVEL_BITS-1:0]   start_reg, start_next;
    logic [LEVEL_BITS-1:0]   prev_reg, prev_next;
    logic                    out_valid_reg, out_valid_next;

    logic [LEVEL_BITS-1:0]   val_reg, val_next;
    logic                    prs_reg, prs_next;
    logic [TIME_BITS-1:0]    pt_reg, pt_next;
    logic [TIME_BITS-1:0]    rt_reg, rt_next;
    logic                    byp_reg, byp_next;
    logic [LEVEL_BITS-1:0]   from_reg, from_next;
    logic                    down_reg, down_next;
    phase_t                  phase_reg, phase_next;
    logic [LEVEL_BITS-1:0]   mcand_reg, mcand_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]    rem_reg, rem_next;
    logic [LEVEL_BITS-1:0]   dq_reg, dq_next;
    logic [TIME_BITS-1:0]    den_reg, den_next;
    logic [LEVEL_BITS-1:0]   level_reg, level_next;
    phase_t                  phase_out_reg, phase_out_next;

    logic [LEVEL_BITS:0]     sus_sat;
    logic [LEVEL_BITS:0]     mul_sum;
    logic [PW-1:0]           mul_prod;
    logic [TIME_BITS:0]      div_sh;
    logic [TIME_BITS:0]      div_dif;
    logic                    div_ge;
    logic [LEVEL_BITS-1:0]   tgt;
    logic [TIME_BITS:0]      dt_ext;
    logic [LEVEL_BITS-1:0]   result;
    logic                    out_free;
    logic [LEVEL_BITS-1:0]   diff;
    logic [TIME_BITS-1:0]    num;
    logic                    go_mul;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign phase     = phase_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        attack_next    = attack_reg;
        decay_next     = decay_reg;
        sustain_next   = sustain_reg;
        release_next   = release_reg;
        start_next     = start_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        val_next       = val_reg;
        prs_next       = prs_reg;
        pt_next        = pt_reg;
        rt_next        = rt_reg;
        byp_next       = byp_reg;
        from_next      = from_reg;
        down_next      = down_reg;
        phase_next     = phase_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        den_next       = den_reg;
        level_next     = level_reg;
        phase_out_next = phase_out_reg;
        diff           = '0;
        num            = '0;
        go_mul         = 1'b0;

        sus_sat  = (sustain_reg > SUS_ONE) ? SUS_ONE : sustain_reg;
        mul_sum  = {1'b0, prod_reg[PW-2:MW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        mul_prod = {1'b0, mul_sum, prod_reg[MW-1:1]};
        div_sh   = {rem_reg, dq_reg[LEVEL_BITS-1]};
        div_dif  = div_sh - {1'b0, den_reg};
        div_ge   = (div_sh >= {1'b0, den_reg});
        tgt      = prod_reg[2*LEVEL_BITS-1:LEVEL_BITS];
        dt_ext   = {1'b0, pt_reg} - {1'b0, attack_reg};
        result   = down_reg ? (from_reg - dq_reg) : (from_reg + dq_reg);
        out_free = !out_valid_reg || out_ready;

        if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ATTACK:  attack_next  = cfg_data[TIME_BITS-1:0];
                REG_DECAY:   decay_next   = cfg_data[TIME_BITS-1:0];
                REG_SUSTAIN: sustain_next = cfg_data[LEVEL_BITS:0];
                REG_RELEASE: release_next = cfg_data[TIME_BITS-1:0];
                default:     ;
            endcase
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = value;
                    prs_next = pressed;
                    pt_next  = since_press;
                    rt_next  = since_release;
                    if (!note_active)
                    begin
                        byp_next   = 1'b1;
                        from_next  = value;
                        dq_next    = '0;
                        down_next  = 1'b0;
                        phase_next = PH_BYPASS;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        byp_next = 1'b0;
                        if ((pressed && since_press == '0) ||
                            (!pressed && since_release == '0))
                        begin
                            start_next = prev_reg;
                        end
                        if (pressed)
                        begin
                            mcand_next = value;
                            prod_next  = PW'(sus_sat);
                            cnt_next   = MUL_LAST;
                            state_next = ST_MUL_T;
                        end
                        else
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                end
            end
            ST_MUL_T:
            begin
                prod_next = mul_prod;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (prs_reg)
                begin
                    if (dt_ext[TIME_BITS])
                    begin
                        phase_next = PH_ATTACK;
                        from_next  = start_reg;
                        if (val_reg < start_reg)
                        begin
                            down_next = 1'b1;
                            diff      = start_reg - val_reg;
                        end
                        else
                        begin
                            down_next = 1'b0;
                            diff      = val_reg - start_reg;
                        end
                        num      = pt_reg;
                        den_next = attack_reg;
                        go_mul   = 1'b1;
                    end
                    else if (dt_ext[TIME_BITS-1:0] < decay_reg)
                    begin
                        phase_next = PH_DECAY;
                        from_next  = val_reg;
                        down_next  = 1'b1;
                        diff       = val_reg - tgt;
                        num        = dt_ext[TIME_BITS-1:0];
                        den_next   = decay_reg;
                        go_mul     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SUSTAIN;
                        from_next  = tgt;
                        down_next  = 1'b0;
                        dq_next    = '0;
                    end
                end
                else
                begin
                    phase_next = PH_RELEASE;
                    down_next  = 1'b0;
                    dq_next    = '0;
                    if (rt_reg > release_reg)
                    begin
                        from_next = '0;
                    end
                    else if (release_reg == '0)
                    begin
                        from_next = start_reg;
                    end
                    else
                    begin
                        from_next = start_reg;
                        down_next = 1'b1;
                        diff      = start_reg;
                        num       = rt_reg;
                        den_next  = release_reg;
                        go_mul    = 1'b1;
                    end
                end
                if (go_mul)
                begin
                    mcand_next = diff;
                    prod_next  = PW'(num);
                    cnt_next   = MUL_LAST;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                prod_next = mul_prod;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next   = mul_prod[LEVEL_BITS+TIME_BITS-1:LEVEL_BITS];
                    dq_next    = mul_prod[LEVEL_BITS-1:0];
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? div_dif[TIME_BITS-1:0] : div_sh[TIME_BITS-1:0];
                dq_next  = {dq_reg[LEVEL_BITS-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    level_next     = result;
                    phase_out_next = phase_reg;
                    out_valid_next = 1'b1;
                    if (!byp_reg)
                    begin
                        prev_next = result;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            attack_reg    <= ATTACK_RST;
            decay_reg     <= DECAY_RST;
            sustain_reg   <= SUS_RST;
            release_reg   <= RELEASE_RST;
            start_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            sustain_reg   <= sustain_next;
            release_reg   <= release_next;
            start_reg     <= start_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        prs_reg       <= prs_next;
        pt_reg        <= pt_next;
        rt_reg        <= rt_next;
        byp_reg       <= byp_next;
        from_reg      <= from_next;
        down_reg      <= down_next;
        phase_reg     <= phase_next;
        mcand_reg     <= mcand_next;
        prod_reg      <= prod_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        den_reg       <= den_next;
        level_reg     <= level_next;
        phase_out_reg <= phase_out_next;
    end

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && down_reg) |-> (dq_reg <= from_reg))
        else $error("ramp step exceeds start level");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !down_reg) |->
        (({1'b0, from_reg} + {1'b0, dq_reg}) <= {1'b0, {LEVEL_BITS{1'b1}}}))
        else $error("ramp step overflows level");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

endmodule

### tb/testbench.sv
// Self-checking testbench for the linear ADSR envelope level shaper.
// Transfers are checked against an in-bench envelope predictor over several register settings.
// Depends on adsr_pkg and adsr_envelope_level.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import adsr_pkg::*;

    localparam int TIME_BITS   = 24;
    localparam int LEVEL_BITS  = 16;
    localparam int CFG_BITS    = 24;
    localparam int STALL_LIMIT = 3000;
    localparam int RUN_CAP     = 40;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct {
        logic [LEVEL_BITS-1:0] value;
        logic                  note_active;
        logic                  pressed;
        logic [TIME_BITS-1:0]  since_press;
        logic [TIME_BITS-1:0]  since_release;
    } sample_t;

    typedef struct {
        logic [LEVEL_BITS-1:0] level;
        phase_t                phase;
    } envelope_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [LEVEL_BITS-1:0] value = '0;
    logic                  note_active = 1'b0;
    logic                  pressed = 1'b0;
    logic [TIME_BITS-1:0]  since_press = '0;
    logic [TIME_BITS-1:0]  since_release = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [LEVEL_BITS-1:0] level;
    phase_t                phase;

    logic [63:0]           attack_ticks = 64'd480;
    logic [63:0]           decay_ticks = 64'd4800;
    logic [63:0]           sustain_frac = 64'd32768;
    logic [63:0]           release_ticks = 64'd4800;
    logic [LEVEL_BITS-1:0] ramp_start = '0;
    logic [LEVEL_BITS-1:0] last_level = '0;

    sample_t   samples_to_send[$];
    envelope_t envelope_due[$];
    logic      in_fire = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        samples_queued = 0;
    int        samples_taken = 0;
    int        results_checked = 0;
    int        settings_used = 1;
    int        error_count = 0;
    int        stall_cycles = 0;
    int        phase_hits[5] = '{default: 0};

    adsr_envelope_level #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .note_active   (note_active),
        .pressed       (pressed),
        .since_press   (since_press),
        .since_release (since_release),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .phase         (phase)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [LEVEL_BITS-1:0] linear_ramp(input logic [63:0] from_lvl,
                                                          input logic [63:0] to_lvl,
                                                          input logic [63:0] num,
                                                          input logic [63:0] den);
        logic [63:0] step;
        if (to_lvl >= from_lvl)
        begin
            step = ((to_lvl - from_lvl) * num) / den;
            return LEVEL_BITS'(from_lvl + step);
        end
        step = ((from_lvl - to_lvl) * num) / den;
        return LEVEL_BITS'(from_lvl - step);
    endfunction

    function automatic envelope_t shape_envelope(input sample_t s);
        envelope_t   r;
        logic [63:0] sus;
        logic [63:0] target;
        logic [63:0] pt;
        logic [63:0] rt;
        logic [63:0] lvl;
        if (!s.note_active)
        begin
            r.level = s.value;
            r.phase = PH_BYPASS;
            return r;
        end
        sus = (sustain_frac > 64'd65536) ? 64'd65536 : sustain_frac;
        pt  = 64'(s.since_press);
        rt  = 64'(s.since_release);
        if (s.pressed)
        begin
            target = (64'(s.value) * sus) >> LEVEL_BITS;
            if (pt == 0)
                ramp_start = last_level;
            if (pt < attack_ticks)
            begin
                lvl = 64'(linear_ramp(64'(ramp_start), 64'(s.value), pt, attack_ticks));
                r.phase = PH_ATTACK;
            end
            else if (pt < attack_ticks + decay_ticks)
            begin
                lvl = 64'(linear_ramp(64'(s.value), target, pt - attack_ticks, decay_ticks));
                r.phase = PH_DECAY;
            end
            else
            begin
                lvl = target;
                r.phase = PH_SUSTAIN;
            end
        end
        else
        begin
            if (rt == 0)
                ramp_start = last_level;
            if (rt > release_ticks)
                lvl = 0;
            else if (release_ticks == 0)
                lvl = 64'(ramp_start);
            else
                lvl = 64'(ramp_start) - (64'(ramp_start) * rt) / release_ticks;
            r.phase = PH_RELEASE;
        end
        r.level    = lvl[LEVEL_BITS-1:0];
        last_level = r.level;
        return r;
    endfunction

    task automatic add_sample(input logic [LEVEL_BITS-1:0] v, input logic act,
                              input logic prs, input logic [TIME_BITS-1:0] sp,
                              input logic [TIME_BITS-1:0] sr);
        sample_t s;
        s.value         = v;
        s.note_active   = act;
        s.pressed       = prs;
        s.since_press   = sp;
        s.since_release = sr;
        samples_to_send.push_back(s);
        samples_queued++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_ATTACK:  attack_ticks  = 64'(data);
            REG_DECAY:   decay_ticks   = 64'(data);
            REG_SUSTAIN: sustain_frac  = 64'(data[LEVEL_BITS:0]);
            REG_RELEASE: release_ticks = 64'(data);
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [CFG_BITS-1:0] a, input logic [CFG_BITS-1:0] d,
                                 input logic [CFG_BITS-1:0] s, input logic [CFG_BITS-1:0] r);
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
        @(negedge clk);
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    task automatic randomise_registers(input bit wide);
        logic [CFG_BITS-1:0] a;
        logic [CFG_BITS-1:0] d;
        logic [CFG_BITS-1:0] s;
        logic [CFG_BITS-1:0] r;
        if (wide)
        begin
            a = CFG_BITS'($urandom_range(0, 24'hFFFFFF));
            d = CFG_BITS'($urandom_range(0, 24'hFFFFFF));
            r = CFG_BITS'($urandom_range(0, 24'hFFFFFF));
        end
        else
        begin
            a = CFG_BITS'($urandom_range(0, 24));
            d = CFG_BITS'($urandom_range(0, 24));
            r = CFG_BITS'($urandom_range(0, 24));
        end
        case ($urandom_range(9))
            0:       s = '0;
            1:       s = CFG_BITS'(65536);
            2:       s = CFG_BITS'($urandom_range(65537, 131071));
            default: s = CFG_BITS'($urandom_range(0, 65536));
        endcase
        set_registers(a, d, s, r);
    endtask

    function automatic int limit_run(input logic [63:0] n);
        return (n > RUN_CAP) ? RUN_CAP : int'(n);
    endfunction

    // one held or released stretch of a note, counter advancing by stride, random bypass samples mixed in
    task automatic queue_run(input logic [LEVEL_BITS-1:0] peak, input logic held,
                             input logic [63:0] from_t, input logic [63:0] stride,
                             input int n);
        logic [63:0]           t;
        logic [TIME_BITS-1:0]  tick;
        logic [LEVEL_BITS-1:0] v;
        v = peak;
        t = from_t;
        for (int k = 0; k < n; k++)
        begin
            tick = (t > 64'(TIME_MAX)) ? TIME_MAX : t[TIME_BITS-1:0];
            if ($urandom_range(99) < 5)
                add_sample(LEVEL_BITS'($urandom), 1'b0, 1'($urandom),
                           TIME_BITS'($urandom), TIME_BITS'($urandom));
            if ($urandom_range(99) < 10)
                v = LEVEL_BITS'($urandom);
            if (held)
                add_sample(v, 1'b1, 1'b1, tick, TIME_BITS'($urandom));
            else
                add_sample(v, 1'b1, 1'b0, TIME_BITS'($urandom), tick);
            t = t + stride;
        end
    endtask

    task automatic queue_random_notes(input int count);
        int                    stop_at;
        int                    roll;
        logic [LEVEL_BITS-1:0] peak;
        logic [63:0]           span;
        logic [63:0]           stride;
        logic [63:0]           reach;
        stop_at = samples_queued + count;
        while (samples_queued < stop_at)
        begin
            roll = $urandom_range(99);
            case ($urandom_range(9))
                0:       peak = '0;
                1:       peak = '1;
                default: peak = LEVEL_BITS'($urandom);
            endcase
            if (roll < 8)
                add_sample(LEVEL_BITS'($urandom), 1'($urandom), 1'($urandom),
                           TIME_BITS'($urandom), TIME_BITS'($urandom));
            else if (roll < 16)
                queue_run(peak, 1'($urandom), 64'($urandom_range(1, 24'hFFFFFF)),
                          64'($urandom_range(1, 65)), $urandom_range(1, 4));
            else
            begin
                span   = attack_ticks + decay_ticks;
                stride = 64'(1 + $urandom_range(0, 32'(span / 8)));
                reach  = span / stride;
                if ($urandom_range(3) != 0)
                    queue_run(peak, 1'b1, 0, stride, limit_run(reach + $urandom_range(1, 4)));
                else
                    queue_run(peak, 1'b1, 0, stride, $urandom_range(1, limit_run(reach + 1)));
                if ($urandom_range(99) < 85)
                begin
                    stride = 64'(1 + $urandom_range(0, 32'(release_ticks / 8)));
                    reach  = release_ticks / stride;
                    queue_run(peak, 1'b0, 0, stride,
                              $urandom_range(1, limit_run(reach + 3)));
                end
            end
        end
    endtask

    task automatic wait_until_drained();
        while (samples_to_send.size() != 0 || in_valid || envelope_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk)
    begin : sample_drive
        sample_t s;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s = samples_to_send.pop_front();
                in_valid      <= 1'b1;
                value         <= s.value;
                note_active   <= s.note_active;
                pressed       <= s.pressed;
                since_press   <= s.since_press;
                since_release <= s.since_release;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        envelope_t want;
        sample_t   s;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (envelope_due.size() == 0)
                begin
                    $error("unexpected result transfer: level %0h phase %0d", level, phase);
                    error_count++;
                end
                else
                begin
                    want = envelope_due.pop_front();
                    results_checked++;
                    phase_hits[want.phase]++;
                    if (level !== want.level)
                    begin
                        $error("level mismatch: expected %0h, actual %0h", want.level, level);
                        error_count++;
                    end
                    if (phase !== want.phase)
                    begin
                        $error("phase mismatch: expected %0d, actual %0d", want.phase, phase);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                s.value         = value;
                s.note_active   = note_active;
                s.pressed       = pressed;
                s.since_press   = since_press;
                s.since_release = since_release;
                envelope_due.push_back(shape_envelope(s));
                samples_taken++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles == STALL_LIMIT)
                begin
                    $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int round;
        send_idle_pct = 22;
        recv_idle_pct = 53;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: bypass, full attack/decay/sustain/release, retrigger
        add_sample(16'hFFFF, 1'b0, 1'b0, 24'd0, 24'd0);
        add_sample(16'h0000, 1'b0, 1'b1, TIME_MAX, TIME_MAX);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd479, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd480, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd5279, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd5280, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, TIME_MAX, 24'd0);
        add_sample(16'h1234, 1'b0, 1'b1, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b0, TIME_MAX, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b0, TIME_MAX, 24'd2400);
        add_sample(16'hFFFF, 1'b1, 1'b0, TIME_MAX, 24'd4800);
        add_sample(16'hFFFF, 1'b1, 1'b0, TIME_MAX, 24'd4801);
        add_sample(16'hFFFF, 1'b1, 1'b0, TIME_MAX, TIME_MAX);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd240, 24'd0);
        add_sample(16'h1000, 1'b1, 1'b1, 24'd0, 24'd0);
        add_sample(16'h1000, 1'b1, 1'b1, 24'd100, 24'd0);
        wait_until_drained();

        // zero times: attack and decay skipped, zero release holds the start level
        set_registers('0, '0, CFG_BITS'(65536), '0);
        add_sample(16'h8000, 1'b1, 1'b1, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, TIME_MAX, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'd1);
        add_sample(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'd0);
        wait_until_drained();

        // longest times, sustain written out of range so it saturates
        set_registers('1, '1, '1, '1);
        add_sample(16'hFFFF, 1'b1, 1'b1, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, TIME_MAX - 1, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b1, TIME_MAX, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'd0);
        add_sample(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'h800000);
        add_sample(16'hFFFF, 1'b1, 1'b0, 24'd0, TIME_MAX);
        wait_until_drained();

        for (round = 0; round < 6; round++)
        begin
            if (round == 2)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 22;
            end
            else if (round == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            randomise_registers(round == 3);
            queue_random_notes(110);
            wait_until_drained();
            queue_random_notes(110);
            wait_until_drained();
        end

        repeat (100) @(posedge clk);
        if (envelope_due.size() != 0)
        begin
            $error("%0d expected results never arrived", envelope_due.size());
            error_count++;
        end
        $display("Checked %0d envelope results from %0d sample transfers over %0d settings",
                 results_checked, samples_taken, settings_used);
        $display("Phase mix: attack %0d, decay %0d, sustain %0d, release %0d, bypass %0d",
                 phase_hits[PH_ATTACK], phase_hits[PH_DECAY], phase_hits[PH_SUSTAIN],
                 phase_hits[PH_RELEASE], phase_hits[PH_BYPASS]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
